// File: src/plid_pkg.sv
`default_nettype none

package plid_pkg;

  // Fixed field widths of the item and result ports
  localparam int KIND_W   = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic                load;       // capture the incoming operation
    logic                start_ins;  // index <- count (topmost target)
    logic                start_del;  // index <- position - 1
    logic                step_ins;   // read index-1, write it to index next cycle
    logic                step_del;   // read index+1, write it to index next cycle
    logic                rd_elem;    // read entry at position - 1
    logic                put;        // write the new value at position - 1
    logic                cnt_inc;
    logic                cnt_dec;
    logic                set_res;    // latch result status
    logic [STATUS_W-1:0] res_status;
    logic                res_rd;     // result carries the read data
    logic                emit;       // load the output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ins_ok;    // 1 <= pos <= count + 1
    logic              rw_ok;     // 1 <= pos <= count
    logic              full;
    logic              ins_end;   // insert shift reached the target slot
    logic              del_end;   // delete shift reached the last entry
    logic              out_free;  // output register can take a result
  } stat_t;

endpackage

`default_nettype wire

// File: src/plid_dp.sv
`default_nettype none

module plid_dp #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire  plid_pkg::cmd_t          cmd_i,
  output plid_pkg::stat_t               stat_o,
  input  wire  [plid_pkg::KIND_W-1:0]   kind_i,
  input  wire  [plid_pkg::POS_W-1:0]    position_i,
  input  wire  [plid_pkg::VALUE_W-1:0]  value_i,
  input  wire                           out_stall_i,
  output logic                          out_valid_o,
  output logic [plid_pkg::STATUS_W-1:0] status_o,
  output logic [plid_pkg::VALUE_W-1:0]  read_value_o,
  output logic [plid_pkg::LEN_W-1:0]    list_length_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W;
  localparam int RW = (ELEMENT_WIDTH > plid_pkg::VALUE_W) ? ELEMENT_WIDTH : plid_pkg::VALUE_W;

  logic [ELEMENT_WIDTH-1:0] mem_q [CAPACITY];

  logic [plid_pkg::KIND_W-1:0]   kind_q;
  logic [plid_pkg::POS_W-1:0]    pos_q;
  logic [ELEMENT_WIDTH-1:0]      val_q;
  logic [CW-1:0]                 count_q, count_d;
  logic [AW-1:0]                 idx_q, idx_d;
  logic [AW-1:0]                 wr_addr_q;
  logic                          wr_pend_q, wr_pend_d;
  logic [ELEMENT_WIDTH-1:0]      rdata_q;
  logic [plid_pkg::STATUS_W-1:0] res_status_q;
  logic                          res_rd_q;
  logic                          out_valid_q, out_valid_d;
  logic [plid_pkg::STATUS_W-1:0] out_status_q;
  logic [plid_pkg::VALUE_W-1:0]  out_value_q;
  logic [plid_pkg::LEN_W-1:0]    out_len_q;

  logic [XW-1:0]     pos_x, cnt_x, p0;
  logic [XW:0]       cnt_p1;
  logic [AW-1:0]     p0_a, rd_addr;
  logic              rd_en;
  logic [RW-1:0]     val_ext, rd_ext;
  logic [CW-1:0]     idx_p1;

  assign pos_x  = XW'(pos_q);
  assign cnt_x  = XW'(count_q);
  assign cnt_p1 = {1'b0, cnt_x} + (XW+1)'(1);
  assign p0     = pos_x - XW'(1);
  assign p0_a   = AW'(p0);
  assign idx_p1 = CW'(idx_q) + CW'(1);
  assign val_ext = RW'(value_i);

  always_comb begin
    stat_o.kind     = kind_q;
    stat_o.ins_ok   = (pos_x != '0) && ({1'b0, pos_x} <= cnt_p1);
    stat_o.rw_ok    = (pos_x != '0) && (pos_x <= cnt_x);
    stat_o.full     = (count_q == CW'(CAPACITY));
    stat_o.ins_end  = (idx_q == p0_a);
    stat_o.del_end  = (idx_p1 == count_q);
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  // read port address select
  always_comb begin
    rd_en = cmd_i.step_ins || cmd_i.step_del || cmd_i.rd_elem;
    if (cmd_i.step_ins) begin
      rd_addr = idx_q - AW'(1);
    end else if (cmd_i.step_del) begin
      rd_addr = idx_q + AW'(1);
    end else begin
      rd_addr = p0_a;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start_ins) begin
      idx_d = AW'(count_q);
    end else if (cmd_i.start_del) begin
      idx_d = p0_a;
    end else if (cmd_i.step_ins) begin
      idx_d = idx_q - AW'(1);
    end else if (cmd_i.step_del) begin
      idx_d = idx_q + AW'(1);
    end
    wr_pend_d = cmd_i.step_ins || cmd_i.step_del;
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // element store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      mem_q[p0_a] <= val_q;
    end else if (wr_pend_q) begin
      mem_q[wr_addr_q] <= rdata_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rd_ext = RW'(rdata_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= val_ext[ELEMENT_WIDTH-1:0];
    end
    idx_q <= idx_d;
    if (cmd_i.step_ins || cmd_i.step_del) begin
      wr_addr_q <= idx_q;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_rd_q     <= cmd_i.res_rd;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_rd_q ? rd_ext[plid_pkg::VALUE_W-1:0] : '0;
      out_len_q    <= plid_pkg::LEN_W'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_value_q;
  assign list_length_o = out_len_q;

endmodule

`default_nettype wire

// File: src/plid_ctrl.sv
`default_nettype none

module plid_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  idle_o,
  input  wire  plid_pkg::stat_t stat_i,
  output plid_pkg::cmd_t        cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SINS  = 3'd2;
  localparam logic [2:0] S_SDEL  = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;

  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = plid_pkg::ST_BADPOS;
        state_d          = S_EMIT;
        case (stat_i.kind)
          plid_pkg::KIND_INSERT: begin
            if (stat_i.ins_ok && stat_i.full) begin
              cmd_o.res_status = plid_pkg::ST_FULL;
            end else if (stat_i.ins_ok) begin
              cmd_o.set_res   = 1'b0;
              cmd_o.start_ins = 1'b1;
              state_d         = S_SINS;
            end
          end
          plid_pkg::KIND_READ: begin
            if (stat_i.rw_ok) begin
              cmd_o.set_res = 1'b0;
              cmd_o.rd_elem = 1'b1;
              state_d       = S_RDW;
            end
          end
          plid_pkg::KIND_DELETE: begin
            if (stat_i.rw_ok) begin
              cmd_o.set_res   = 1'b0;
              cmd_o.start_del = 1'b1;
              state_d         = S_SDEL;
            end
          end
          default: ;
        endcase
      end
      S_SINS: begin
        // last pending move lands this cycle when the end is reached
        if (stat_i.ins_end) begin
          state_d = S_PUT;
        end else begin
          cmd_o.step_ins = 1'b1;
        end
      end
      S_PUT: begin
        cmd_o.put        = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = plid_pkg::ST_OK;
        state_d          = S_EMIT;
      end
      S_SDEL: begin
        if (stat_i.del_end) begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = plid_pkg::ST_OK;
          state_d          = S_EMIT;
        end else begin
          cmd_o.step_del = 1'b1;
        end
      end
      S_RDW: begin
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = plid_pkg::ST_OK;
        cmd_o.res_rd     = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: src/positional_list_insert_delete.sv
// Channel  Direction  Handshake              Payload
// in       sink       in_valid_i/in_stall_o  kind_i, position_i, value_i
// out      source     out_valid_o/out_stall_i status_o, read_value_o, list_length_o
//
// One item at a time. An insert or a delete first shifts the tail of the list
// that starts at the given position; a read or a rejected item needs no
// shift. The shift moves one entry per cycle through the single read and
// write port of the element store.
// Reset clears the length and all control; the element store is not cleared.
// A stalled result sits in the output register; the next item is taken
// meanwhile and only its own result waits for the register to free.
`default_nettype none

module positional_list_insert_delete #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [plid_pkg::KIND_W-1:0]   kind_i,
  input  wire  [plid_pkg::POS_W-1:0]    position_i,
  input  wire  [plid_pkg::VALUE_W-1:0]  value_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [plid_pkg::STATUS_W-1:0] status_o,
  output logic [plid_pkg::VALUE_W-1:0]  read_value_o,
  output logic [plid_pkg::LEN_W-1:0]    list_length_o
);

  plid_pkg::cmd_t  cmd;
  plid_pkg::stat_t stat;
  logic            idle;

  // controller takes an item only when idle
  assign in_stall_o = !idle;

  plid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .idle_o     (idle),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // store, length counter, shift index and output register
  plid_dp #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .list_length_o (list_length_o)
  );

  // a taken item keeps the block busy for the following cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // a full status only comes from a list at capacity
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == plid_pkg::ST_FULL) |->
      (list_length_o == plid_pkg::LEN_W'(CAPACITY)))
    else $error("full status with list below capacity");

  // read data only on a successful read
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != plid_pkg::ST_OK) |-> (read_value_o == '0))
    else $error("read data on a failed item");

  // shift moves never overlap the final store of an insert
  a_put_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.put |-> !cmd.step_ins && !cmd.step_del && !$past(cmd.step_ins))
    else $error("insert store collides with a pending move");

endmodule

`default_nettype wire

// File: tb/sv/plid_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the list block, keeps its own copy of the list
// and checks every result transfer against the oldest outstanding outcome.
module plid_checker
  import plid_pkg::*;
#(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_stall_i,
  input  wire  [KIND_W-1:0]   kind_i,
  input  wire  [POS_W-1:0]    position_i,
  input  wire  [VALUE_W-1:0]  value_i,
  input  wire                 out_valid_i,
  input  wire                 out_stall_i,
  input  wire  [STATUS_W-1:0] status_i,
  input  wire  [VALUE_W-1:0]  read_value_i,
  input  wire  [LEN_W-1:0]    list_length_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [LEN_W-1:0]    length;
  } list_outcome_t;

  // Shadow list, element 0 is list position 1
  logic [ELEMENT_WIDTH-1:0] elems[$];
  list_outcome_t            outcomes_due[$];
  list_outcome_t            due;

  function automatic list_outcome_t apply_list_op(input logic [KIND_W-1:0]  op,
                                                  input logic [POS_W-1:0]   pos,
                                                  input logic [VALUE_W-1:0] val);
    list_outcome_t res;
    int            slot;
    res            = '0;
    res.status     = ST_BADPOS;
    slot           = int'(pos) - 1;
    case (op)
      KIND_INSERT: begin
        if (pos != 0 && slot <= elems.size()) begin
          // position check comes before the full check
          if (elems.size() >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            elems.insert(slot, val[ELEMENT_WIDTH-1:0]);
            res.status = ST_OK;
          end
        end
      end
      KIND_READ: begin
        if (pos != 0 && slot < elems.size()) begin
          res.read_value = elems[slot];
          res.status     = ST_OK;
        end
      end
      KIND_DELETE: begin
        if (pos != 0 && slot < elems.size()) begin
          elems.delete(slot);
          res.status = ST_OK;
        end
      end
      default: ;  // spare kind: rejected as bad position
    endcase
    res.length = LEN_W'(elems.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elems.delete();
      outcomes_due.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // result first: it can never belong to an item taken at this same edge
      if (out_valid_i && !out_stall_i) begin
        if (outcomes_due.size() == 0) begin
          $error("result transfer with no outstanding item");
          mismatches_o++;
        end else begin
          due = outcomes_due.pop_front();
          if (status_i !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status_i);
            mismatches_o++;
          end
          if (read_value_i !== due.read_value) begin
            $error("read_value: expected %h, got %h", due.read_value, read_value_i);
            mismatches_o++;
          end
          if (list_length_i !== due.length) begin
            $error("list_length: expected %0d, got %0d", due.length, list_length_i);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        outcomes_due.push_back(apply_list_op(kind_i, position_i, value_i));
      end
      pending_o = outcomes_due.size();
    end
  end

endmodule

// File: tb/sv/positional_list_insert_delete_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the positional list. All checking happens in
// plid_checker; this module only feeds operations, stalls the result side
// and watches for a hang.
module positional_list_insert_delete_tb;
  import plid_pkg::*;

  localparam int CAPACITY      = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int ITEM_TARGET   = 1050;
  // Worst legal quiet stretch is roughly a full-length shift plus the longest
  // result stall and sender gap; keep a wide margin.
  localparam int HANG_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 100;

  // Kind 3 has no operation behind it; the block must reject it.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // Random round flavors
  localparam int LEAN_GROW   = 0;
  localparam int LEAN_SHRINK = 1;
  localparam int LEAN_MIXED  = 2;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic [KIND_W-1:0]   kind_i        = '0;
  logic [POS_W-1:0]    position_i    = '0;
  logic [VALUE_W-1:0]  value_i       = '0;
  logic                out_stall_i   = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [VALUE_W-1:0]  read_value_o;
  logic [LEN_W-1:0]    list_length_o;

  int mismatches;
  int outstanding;

  // Sender-side bookkeeping: list length as seen by the stimulus, used only
  // to aim positions at the interesting spots (ends, just past the end).
  int list_len;
  int items_sent;
  int burst_left;

  always #5 clk_i = ~clk_i;

  positional_list_insert_delete #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .list_length_o (list_length_o)
  );

  plid_checker #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .read_value_i  (read_value_o),
    .list_length_i (list_length_o),
    .mismatches_o  (mismatches),
    .pending_o     (outstanding)
  );

  // Result-side back-pressure. Each mode holds for a random stretch:
  // free flow, light random, heavy random, or long solid stall bursts.
  int stall_mode;
  int mode_left;
  int solid_left;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(3);
      mode_left  = $urandom_range(300, 50);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(3) == 0);
      2: out_stall_i <= ($urandom_range(3) != 0);
      default: begin
        if (solid_left > 0) begin
          solid_left--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
          if ($urandom_range(7) == 0) solid_left = $urandom_range(40, 1);
        end
      end
    endcase
  end

  // Hang detector: any stretch with no transfer on either channel.
  int quiet_cycles;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("positional_list_insert_delete: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One operation transfer. Called at a rising edge; returns at the edge
  // where the block took it. Gaps between bursts drop valid first, so valid
  // is never lowered and raised within one step.
  task automatic send_op(input logic [KIND_W-1:0] op, input int pos,
                         input logic [VALUE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(9) < 3) ? 0 : $urandom_range(8, 1);
      burst_left = $urandom_range(16, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    kind_i     <= op;
    position_i <= POS_W'(pos);
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    items_sent++;
    // track length for position aiming only
    if (op == KIND_INSERT && pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY)
      list_len++;
    else if (op == KIND_DELETE && pos >= 1 && pos <= list_len)
      list_len--;
  endtask

  // Random operation with edge-heavy values and positions. A small share is
  // noise: spare kind, position 0, just past the end, or far out of range.
  task automatic random_op(input int leaning);
    logic [KIND_W-1:0]  op;
    logic [VALUE_W-1:0] val;
    int                 pos;
    int                 roll;
    case ($urandom_range(9))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
    roll = $urandom_range(99);
    if (roll < 8) begin
      op = KIND_W'($urandom_range(3));
      case ($urandom_range(3))
        0:       pos = 0;
        1:       pos = list_len + ((op == KIND_INSERT) ? 2 : 1);
        2:       pos = $urandom_range(127);
        default: pos = $urandom_range(127, 66);
      endcase
    end else begin
      roll = $urandom_range(99);
      case (leaning)
        LEAN_GROW:   op = (roll < 80) ? KIND_INSERT : (roll < 90) ? KIND_READ : KIND_DELETE;
        LEAN_SHRINK: op = (roll < 80) ? KIND_DELETE : (roll < 90) ? KIND_READ : KIND_INSERT;
        default:     op = (roll < 40) ? KIND_INSERT : (roll < 70) ? KIND_READ : KIND_DELETE;
      endcase
      if (op == KIND_INSERT) begin
        case ($urandom_range(3))
          0:       pos = 1;
          1:       pos = list_len + 1;
          default: pos = $urandom_range(list_len + 1, 1);
        endcase
      end else if (list_len == 0) begin
        pos = 1;  // empty list: rejected
      end else begin
        case ($urandom_range(3))
          0:       pos = 1;
          1:       pos = list_len;
          default: pos = $urandom_range(list_len, 1);
        endcase
      end
    end
    send_op(op, pos, val);
  endtask

  initial begin
    int round_lean;
    int round_len;
    list_len   = 0;
    items_sent = 0;
    burst_left = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list rejects, bad positions, front/middle/end inserts,
    // extreme values, reads at both ends, deletes at both ends, spare kind.
    send_op(KIND_READ,   1,   '0);
    send_op(KIND_DELETE, 1,   '0);
    send_op(KIND_INSERT, 0,   32'h1234_5678);
    send_op(KIND_INSERT, 2,   32'h1234_5678);
    send_op(KIND_INSERT, 1,   '0);
    send_op(KIND_INSERT, 1,   '1);
    send_op(KIND_INSERT, 3,   32'hA5A5_A5A5);
    send_op(KIND_INSERT, 2,   32'h5A5A_5A5A);
    send_op(KIND_READ,   1,   '0);
    send_op(KIND_READ,   4,   '1);
    send_op(KIND_READ,   2,   '0);
    send_op(KIND_READ,   5,   '0);
    send_op(KIND_READ,   0,   '0);
    send_op(KIND_DELETE, 0,   '0);
    send_op(KIND_DELETE, 5,   '0);
    send_op(KIND_DELETE, 1,   '1);
    send_op(KIND_DELETE, 3,   '0);
    send_op(KIND_DELETE, 127, '0);
    send_op(KIND_INSERT, 127, '1);
    send_op(KIND_SPARE,  1,   '0);
    send_op(KIND_SPARE,  0,   '1);
    send_op(KIND_READ,   1,   '0);
    send_op(KIND_READ,   2,   '0);
    send_op(KIND_DELETE, 1,   '0);
    send_op(KIND_DELETE, 1,   '0);

    // Fill to capacity so the full-list path and the longest shifts are hit,
    // then knock on the full list at the end, the front and the middle.
    while (list_len < CAPACITY) random_op(LEAN_GROW);
    send_op(KIND_INSERT, list_len + 1, 32'hDEAD_BEEF);
    send_op(KIND_INSERT, 1,            32'hDEAD_BEEF);
    send_op(KIND_INSERT, 33,           32'hDEAD_BEEF);
    send_op(KIND_INSERT, list_len + 2, 32'hDEAD_BEEF);

    // Random rounds that swing the length between empty and full.
    while (items_sent < ITEM_TARGET) begin
      round_lean = $urandom_range(LEAN_MIXED);
      round_len  = $urandom_range(80, 20);
      repeat (round_len) random_op(round_lean);
    end
    in_valid_i <= 1'b0;

    // Drain, then give any stray result time to show up.
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("positional_list_insert_delete: match");
    end else begin
      $display("positional_list_insert_delete: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/plid_pkg.sv
src/plid_dp.sv
src/plid_ctrl.sv
src/positional_list_insert_delete.sv
tb/sv/plid_checker.sv
tb/sv/positional_list_insert_delete_tb.sv
